/* rtl/hhk_pkg.sv */
`timescale 1ns / 1ps
// Package for the Hodgkin-Huxley potassium current block: payload types,
// register codes, reset values and the rate-table builder functions.
// No dependencies.
package hhk_pkg;

  typedef enum logic [1:0] {
    CFG_CONDUCTANCE = 2'd0,
    CFG_REVERSAL    = 2'd1,
    CFG_TIME_STEP   = 2'd2,
    CFG_N_INIT      = 2'd3
  } hhk_cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] prev_voltage;
    logic               same_compartment;
  } hhk_in_t;

  typedef struct packed {
    logic signed [31:0] current;
    logic               current_valid;
    logic [15:0]        gating_value;
  } hhk_out_t;

  typedef struct packed {
    hhk_cfg_idx_e addr;
    logic [15:0]  wdata;
  } hhk_cfg_t;

  typedef struct packed {
    logic en;
    logic clear;
    logic hi;
  } hhk_mac_ctl_t;

  typedef struct packed {
    logic en;
    logic beta;
  } hhk_rom_req_t;

  localparam int MUL_A_W  = 34;
  localparam int MUL_B_W  = 20;
  localparam int ACC_W    = 64;
  localparam int HI_SHIFT = 34;

  localparam logic [15:0] CONDUCTANCE_RST = 16'd2560;
  localparam logic [15:0] REVERSAL_RST    = 16'hA600;
  localparam logic [15:0] TIME_STEP_RST   = 16'd655;
  localparam logic [15:0] N_INIT_RST      = 16'd0;
  localparam logic [18:0] TEMP_FACTOR     = 19'd5;

  localparam logic [63:0] E_Q24           = 64'd45605201;
  localparam logic [63:0] INV_E_Q24       = 64'd6171993;
  localparam logic [63:0] ONE_Q24         = 64'd16777216;
  localparam logic [31:0] ALPHA_LIMIT_Q16 = 32'd6554;

  // Shift-subtract division, evaluated only while building the tables.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q40.24 exponential of a Q16.16 argument clamped to [-20, 10].
  function automatic logic [63:0] exp_q24(int t);
    int          tc;
    int          k;
    logic [31:0] tt;
    logic [63:0] r;
    logic [63:0] sum;
    logic [63:0] term;
    tc = t;
    if (tc < -20 * 65536) tc = -20 * 65536;
    if (tc > 10 * 65536) tc = 10 * 65536;
    tt   = 32'(tc + 32 * 65536);
    k    = int'(tt[31:16]) - 32;
    r    = 64'(tt[15:0]) << 8;
    sum  = ONE_Q24;
    term = ONE_Q24;
    for (int i = 1; i <= 12; i++) begin
      term = udiv64((term * r) >> 24, 64'(i));
      sum  = sum + term;
    end
    for (int j = 0; j < 32; j++) begin
      if (k > 0) begin
        sum = (sum * E_Q24 + 64'h80_0000) >> 24;
        k   = k - 1;
      end else if (k < 0) begin
        sum = (sum * INV_E_Q24 + 64'h80_0000) >> 24;
        k   = k + 1;
      end
    end
    return sum;
  endfunction

  function automatic int scaled_arg(int w, int divisor);
    logic [63:0] mag;
    logic [63:0] tm;
    mag = 64'(w < 0 ? -w : w);
    tm  = udiv64(mag * 256 + 64'(divisor >> 1), 64'(divisor));
    return (w > 0) ? -int'(tm) : int'(tm);
  endfunction

  function automatic logic [31:0] alpha_at(int v);
    int          u;
    logic [63:0] mag;
    logic [63:0] ex;
    logic [63:0] den;
    logic [63:0] val;
    u = v + 34 * 256;
    if (u == 0) return ALPHA_LIMIT_Q16;
    mag = 64'(u < 0 ? -u : u);
    ex  = exp_q24(scaled_arg(u, 10));
    den = (ex > ONE_Q24) ? ex - ONE_Q24 : ONE_Q24 - ex;
    if (den == 0) return ALPHA_LIMIT_Q16;
    val = udiv64((mag << 32) + 64'd50 * den, 64'd100 * den);
    return (val > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : val[31:0];
  endfunction

  function automatic logic [31:0] beta_at(int v);
    logic [63:0] ex;
    logic [63:0] val;
    ex  = exp_q24(scaled_arg(v + 44 * 256, 80));
    val = (ex + 64'd1024) >> 11;
    return (val > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : val[31:0];
  endfunction

endpackage

/* rtl/hhk_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload of type T per transfer.
// No dependencies.
interface hhk_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/hh_potassium_current_step.sv */
`timescale 1ns / 1ps
// Top level of the Hodgkin-Huxley potassium current step.
// Depends on hhk_pkg, hhk_stream_if, hhk_rate_rom and hhk_mac.
//
//   channel  dir  payload                                          transfer when
//   in_i     in   prev_voltage, same_compartment                   valid & ready
//   out_o    out  current, current_valid, gating_value             valid & ready
//   cfg_i    in   addr (register index), wdata                     valid & ready
//
// Each item is taken in an input transfer and then passes through 19 steps of
// a sequencer that drives the single shared multiply-accumulate unit and the
// rate table read port, at most one operation of each per step.
// Reset clears the sequencer, the result flag, the configuration registers
// and the gating state; the tables are constants and need no clearing pass.
// A finished result sits in the output register, so a new item is taken
// while it waits; only when a second result is ready before the first is
// taken does the sequencer hold in its last step.
module hh_potassium_current_step import hhk_pkg::*; #(
  parameter int RATE_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hhk_stream_if.sink   in_i,
  hhk_stream_if.source out_o,
  hhk_stream_if.sink   cfg_i
);

  localparam int IW = $clog2(RATE_TABLE_DEPTH + 1);
  localparam int PW = 16 + IW;

  // One-hot sequencer. The steps in order: read the two alpha entries and
  // interpolate, the same for beta, form gain and loss of the Euler step,
  // scale by dt * 5, round and clamp n, two squarings, then g * n^4 * |V-E|.
  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_RA0  = 20'h00002,
    ST_RA1  = 20'h00004,
    ST_RB0  = 20'h00008,
    ST_RB1  = 20'h00010,
    ST_BF   = 20'h00020,
    ST_GAIN = 20'h00040,
    ST_LOSS = 20'h00080,
    ST_DIFF = 20'h00100,
    ST_E0   = 20'h00200,
    ST_E1   = 20'h00400,
    ST_NUP  = 20'h00800,
    ST_NCL  = 20'h01000,
    ST_SQ1  = 20'h02000,
    ST_R2   = 20'h04000,
    ST_SQ2  = 20'h08000,
    ST_R4   = 20'h10000,
    ST_GN   = 20'h20000,
    ST_GD   = 20'h40000,
    ST_FIN  = 20'h80000
  } state_e;

  state_e state_d, state_q;

  // Configuration and gating state.
  logic [15:0]        g_q;
  logic signed [15:0] e_q;
  logic [15:0]        dt_q;
  logic [15:0]        n_q;

  // Per-item working registers.
  logic signed [15:0] v_q;
  logic               same_q;
  logic [IW-1:0]      idx_q;
  logic [15:0]        frac_q;
  logic [15:0]        dm_q;
  logic               dpos_q;
  logic [31:0]        a_q;
  logic [31:0]        b_q;
  logic [47:0]        gain_q;
  logic [47:0]        dmag_q;
  logic               neg_q;
  logic [31:0]        step_q;
  logic [15:0]        n2_q;
  logic [15:0]        n4_q;

  hhk_out_t           out_q;
  logic               out_valid_q;

  // Shared unit and table port.
  hhk_mac_ctl_t        mac_ctl;
  logic [MUL_A_W-1:0]  mac_a;
  logic [MUL_B_W-1:0]  mac_b;
  logic [ACC_W-1:0]    acc;
  hhk_rom_req_t        rom_req;
  logic [IW-1:0]       rom_addr;
  logic [31:0]         rom_data;

  logic               in_fire;
  logic               fin_load;
  logic [PW-1:0]      pos;
  logic [IW-1:0]      idx_raw;
  logic [16:0]        frac_inv;
  logic [16:0]        n_inv;
  logic [18:0]        dt5;
  logic [ACC_W-1:0]   acc_rnd16;
  logic [ACC_W-1:0]   acc_rnd31;
  logic [ACC_W-1:0]   acc_rnd23;
  logic signed [16:0] dv;
  logic [16:0]        dv_abs;
  logic [33:0]        nn;
  logic [39:0]        cur_mag;
  logic [31:0]        cur_sat;
  logic [31:0]        cur_val;

  hhk_rate_rom #(
    .DEPTH (RATE_TABLE_DEPTH),
    .IW    (IW)
  ) u_rom (
    .clk_i  (clk_i),
    .req_i  (rom_req),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  hhk_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign fin_load    = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);

  // Table position: the voltage offset to unsigned, scaled by the depth.
  assign pos = PW'({~in_i.data.prev_voltage[15], in_i.data.prev_voltage[14:0]})
             * PW'(RATE_TABLE_DEPTH);
  assign idx_raw = (pos[PW-1:16] >= IW'(RATE_TABLE_DEPTH)) ?
                   IW'(RATE_TABLE_DEPTH - 1) : pos[PW-1:16];

  assign frac_inv  = 17'h10000 - 17'(frac_q);
  assign n_inv     = 17'h10000 - 17'(n_q);
  assign dt5       = 19'(dt_q) * TEMP_FACTOR;
  assign acc_rnd16 = acc + ACC_W'(32768);
  assign acc_rnd31 = acc + (ACC_W'(1) << 31);
  assign acc_rnd23 = acc + (ACC_W'(1) << 23);

  // Driving force V - E and its magnitude, computed once per item.
  assign dv     = 17'(v_q) - 17'(e_q);
  assign dv_abs = dv[16] ? -dv : dv;

  // Euler update of n, then clamp to the Q0.16 range.
  assign nn = neg_q ? (34'(n_q) - 34'(step_q)) : (34'(n_q) + 34'(step_q));

  // Current magnitude rounded to Q23.8, saturated, then signed by E - V.
  assign cur_mag = acc_rnd23[63:24];
  always_comb begin
    if (cur_mag > 40'h7FFF_FFFF) begin
      cur_sat = dpos_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      cur_sat = cur_mag[31:0];
    end
    if (!same_q) begin
      cur_val = '0;
    end else if (dpos_q) begin
      cur_val = -cur_sat;
    end else begin
      cur_val = cur_sat;
    end
  end

  // Sequencer: at most one operation of the shared unit and of the table port per step.
  always_comb begin
    state_d  = state_q;
    mac_ctl  = '0;
    mac_a    = '0;
    mac_b    = '0;
    rom_req  = '0;
    rom_addr = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_RA0;
      end
      ST_RA0: begin
        rom_req.en = 1'b1;
        state_d    = ST_RA1;
      end
      ST_RA1: begin
        rom_req.en = 1'b1;
        rom_addr   = idx_q + IW'(1);
        mac_ctl    = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
        mac_a      = MUL_A_W'(rom_data);
        mac_b      = MUL_B_W'(frac_inv);
        state_d    = ST_RB0;
      end
      ST_RB0: begin
        rom_req = '{en: 1'b1, beta: 1'b1};
        mac_ctl = '{en: 1'b1, clear: 1'b0, hi: 1'b0};
        mac_a   = MUL_A_W'(rom_data);
        mac_b   = MUL_B_W'(frac_q);
        state_d = ST_RB1;
      end
      ST_RB1: begin
        rom_req  = '{en: 1'b1, beta: 1'b1};
        rom_addr = idx_q + IW'(1);
        mac_ctl  = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
        mac_a    = MUL_A_W'(rom_data);
        mac_b    = MUL_B_W'(frac_inv);
        state_d  = ST_BF;
      end
      ST_BF: begin
        mac_ctl = '{en: 1'b1, clear: 1'b0, hi: 1'b0};
        mac_a   = MUL_A_W'(rom_data);
        mac_b   = MUL_B_W'(frac_q);
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        mac_ctl = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
        mac_a   = MUL_A_W'(a_q);
        mac_b   = MUL_B_W'(n_inv);
        state_d = ST_LOSS;
      end
      ST_LOSS: begin
        mac_ctl = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
        mac_a   = MUL_A_W'(b_q);
        mac_b   = MUL_B_W'(n_q);
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        state_d = ST_E0;
      end
      ST_E0: begin
        mac_ctl = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
        mac_a   = dmag_q[33:0];
        mac_b   = MUL_B_W'(dt5);
        state_d = ST_E1;
      end
      ST_E1: begin
        mac_ctl = '{en: 1'b1, clear: 1'b0, hi: 1'b1};
        mac_a   = MUL_A_W'(dmag_q[47:34]);
        mac_b   = MUL_B_W'(dt5);
        state_d = ST_NUP;
      end
      ST_NUP: begin
        state_d = ST_NCL;
      end
      ST_NCL: begin
        state_d = ST_SQ1;
      end
      ST_SQ1: begin
        mac_ctl = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
        mac_a   = MUL_A_W'(n_q);
        mac_b   = MUL_B_W'(n_q);
        state_d = ST_R2;
      end
      ST_R2: begin
        state_d = ST_SQ2;
      end
      ST_SQ2: begin
        mac_ctl = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
        mac_a   = MUL_A_W'(n2_q);
        mac_b   = MUL_B_W'(n2_q);
        state_d = ST_R4;
      end
      ST_R4: begin
        state_d = ST_GN;
      end
      ST_GN: begin
        mac_ctl = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
        mac_a   = MUL_A_W'(g_q);
        mac_b   = MUL_B_W'(n4_q);
        state_d = ST_GD;
      end
      ST_GD: begin
        mac_ctl = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
        mac_a   = MUL_A_W'(acc[31:0]);
        mac_b   = MUL_B_W'(dm_q);
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state, configuration and gating state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      g_q         <= CONDUCTANCE_RST;
      e_q         <= REVERSAL_RST;
      dt_q        <= TIME_STEP_RST;
      n_q         <= N_INIT_RST;
    end else begin
      state_q <= state_d;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.data.addr)
          CFG_CONDUCTANCE: g_q  <= cfg_i.data.wdata;
          CFG_REVERSAL:    e_q  <= cfg_i.data.wdata;
          CFG_TIME_STEP:   dt_q <= cfg_i.data.wdata;
          CFG_N_INIT:      n_q  <= cfg_i.data.wdata;
          default: ;
        endcase
      end else if (state_q == ST_NCL) begin
        if (nn[33]) begin
          n_q <= '0;
        end else if (nn > 34'd65535) begin
          n_q <= 16'hFFFF;
        end else begin
          n_q <= nn[15:0];
        end
      end
    end
  end

  // Working registers, each group loaded in its own step.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          v_q    <= in_i.data.prev_voltage;
          same_q <= in_i.data.same_compartment;
          idx_q  <= idx_raw;
          frac_q <= pos[15:0];
        end
      end
      ST_RA0: begin
        dm_q   <= dv_abs[15:0];
        dpos_q <= !dv[16] && (dv != '0);
      end
      ST_RB1:  a_q    <= acc_rnd16[47:16];
      ST_GAIN: b_q    <= acc_rnd16[47:16];
      ST_LOSS: gain_q <= acc[47:0];
      ST_DIFF: begin
        neg_q  <= acc[47:0] > gain_q;
        dmag_q <= (acc[47:0] > gain_q) ? (acc[47:0] - gain_q) : (gain_q - acc[47:0]);
      end
      ST_NUP:  step_q <= acc_rnd31[63:32];
      ST_R2:   n2_q   <= acc_rnd16[31:16];
      ST_R4:   n4_q   <= acc_rnd16[31:16];
      ST_FIN: begin
        if (fin_load) begin
          out_q.current       <= cur_val;
          out_q.current_valid <= same_q;
          out_q.gating_value  <= n_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

/* rtl/hhk_rate_rom.sv */
`timescale 1ns / 1ps
// Alpha and beta rate tables with one registered read port.
// Depends on hhk_pkg for the table builder functions.
module hhk_rate_rom import hhk_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int IW    = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  hhk_rom_req_t  req_i,
  input  logic [IW-1:0] addr_i,
  output logic [31:0]   data_o
);

  logic [31:0] alpha_tab [DEPTH+1];
  logic [31:0] beta_tab  [DEPTH+1];
  logic [31:0] data_q;

  // Entry g sits at voltage floor(g * 65536 / DEPTH) - 32768 (Q8.8).
  for (genvar g = 0; g <= DEPTH; g++) begin : g_ent
    localparam int          VOLT = int'((longint'(g) * 65536) / DEPTH) - 32768;
    localparam logic [31:0] AVAL = alpha_at(VOLT);
    localparam logic [31:0] BVAL = beta_at(VOLT);
    assign alpha_tab[g] = AVAL;
    assign beta_tab[g]  = BVAL;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      data_q <= req_i.beta ? beta_tab[addr_i] : alpha_tab[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

/* rtl/hhk_mac.sv */
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one 34x20 product per cycle while enabled
// into a 64-bit accumulator that wraps. Depends on hhk_pkg.
module hhk_mac import hhk_pkg::*; (
  input  logic               clk_i,
  input  hhk_mac_ctl_t       ctl_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [ACC_W-1:0]   acc_o
);

  logic [MUL_A_W+MUL_B_W-1:0] prod;
  logic [ACC_W-1:0]           addend;
  logic [ACC_W-1:0]           acc_d, acc_q;

  assign prod   = {{MUL_B_W{1'b0}}, a_i} * {{MUL_A_W{1'b0}}, b_i};
  assign addend = ctl_i.hi ? ACC_W'({prod, {HI_SHIFT{1'b0}}}) : ACC_W'(prod);
  assign acc_d  = (ctl_i.clear ? '0 : acc_q) + addend;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* rtl/hhk_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for hh_potassium_current_step and the bind that
// attaches them. Depends on hhk_pkg and the top level.
module hhk_checker import hhk_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input hhk_out_t out_data_i
);

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item was in work");

  // A result appears only at the end of work, never out of an idle block.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an item in work");

  // The extracellular case carries a zero current.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.current_valid |-> out_data_i.current == '0)
    else $error("invalid result with nonzero current");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

endmodule

bind hh_potassium_current_step hhk_checker u_hhk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
